@@ hw/rtl/far_pkg.sv @@
package far_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_WIDTH = 2 * OPERAND_WIDTH;
	localparam int RES_WIDTH = 2 * OPERAND_WIDTH + 1;
	localparam int DIV_CNT_WIDTH = $clog2(RES_WIDTH);

	typedef logic signed [OPERAND_WIDTH-1:0] far_opnd_t;
	typedef logic signed [PROD_WIDTH-1:0] far_prod_t;
	typedef logic signed [RES_WIDTH-1:0] far_res_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_RED = 3'd4
	} far_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_EUC,
		ST_GCD_WAIT,
		ST_NUM_WAIT,
		ST_DEN_WAIT,
		ST_OUT
	} far_state_t;

endpackage

@@ hw/rtl/far_if.sv @@
interface far_req_if import far_pkg::*;;
	logic valid;
	logic ready;
	logic [2:0] opcode;
	far_opnd_t a_num;
	far_opnd_t a_den;
	far_opnd_t b_num;
	far_opnd_t b_den;

	modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface far_rsp_if import far_pkg::*;;
	logic valid;
	logic ready;
	far_res_t res_num;
	far_res_t res_den;
	logic zero_divisor;

	modport source (output valid, res_num, res_den, zero_divisor, input ready);
	modport sink (input valid, res_num, res_den, zero_divisor, output ready);
endinterface

@@ hw/rtl/far_div.sv @@
module far_div import far_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  far_res_t dividend,
	input  far_res_t divisor,
	output logic     done,
	output far_res_t quot,
	output far_res_t rem
);

	logic                     busy_q;
	logic                     done_q;
	logic [DIV_CNT_WIDTH-1:0] cnt_q;
	logic [RES_WIDTH-1:0]     quo_q;
	logic [RES_WIDTH-1:0]     rem_q;
	logic [RES_WIDTH-1:0]     dsr_q;
	logic                     qneg_q;
	logic                     rneg_q;

	logic [RES_WIDTH-1:0] dvd_mag;
	logic [RES_WIDTH-1:0] dsr_mag;
	logic [RES_WIDTH:0]   shifted;
	logic [RES_WIDTH:0]   diff;
	logic                 fits;

	assign dvd_mag = dividend[RES_WIDTH-1] ? RES_WIDTH'(-dividend) : RES_WIDTH'(dividend);
	assign dsr_mag = divisor[RES_WIDTH-1] ? RES_WIDTH'(-divisor) : RES_WIDTH'(divisor);
	assign shifted = {rem_q, quo_q[RES_WIDTH-1]};
	assign diff = shifted - {1'b0, dsr_q};
	assign fits = !diff[RES_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_WIDTH'(RES_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd_mag;
			rem_q <= '0;
			dsr_q <= dsr_mag;
			qneg_q <= dividend[RES_WIDTH-1] ^ divisor[RES_WIDTH-1];
			rneg_q <= dividend[RES_WIDTH-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[RES_WIDTH-2:0], fits};
			rem_q <= fits ? diff[RES_WIDTH-1:0] : shifted[RES_WIDTH-1:0];
		end
	end

	assign done = done_q;
	assign quot = qneg_q ? far_res_t'(-quo_q) : far_res_t'(quo_q);
	assign rem = rneg_q ? far_res_t'(-rem_q) : far_res_t'(rem_q);

endmodule

@@ hw/rtl/fraction_arith_reduce_core.sv @@
// Each item is cross-multiplied on one 16x16 multiplier (not for reduce); then the shared
// bit-serial divider runs the Euclid remainder steps and divides the numerator and the
// denominator by the gcd, and the result is then loaded into the output register.
// Throughput: one item at a time; a new item is taken in the cycle after the result is
// loaded, and the load waits while the previous result is unread.
// Reset asynchronously clears the state machine, the output valid flag and the divider control.
module fraction_arith_reduce_core import far_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	far_req_if.sink     req,
	far_rsp_if.source   rsp
);

	far_state_t state_q;
	far_state_t state_d;
	far_op_t    op_q;
	logic [1:0] cnt_q;
	far_opnd_t  an_q;
	far_opnd_t  ad_q;
	far_opnd_t  bn_q;
	far_opnd_t  bd_q;
	far_prod_t  prod_q;
	far_res_t   n_q;
	far_res_t   d_q;
	far_res_t   p_q;
	far_res_t   q_q;
	far_res_t   num_q;
	far_res_t   den_q;
	logic       err_q;
	far_res_t   res_num_q;
	far_res_t   res_den_q;
	logic       zd_q;
	logic       out_valid_q;

	far_op_t   op_in;
	far_opnd_t mul_a;
	far_opnd_t mul_b;
	far_prod_t prod;
	logic      div_start;
	far_res_t  div_dvd;
	far_res_t  div_dsr;
	logic      div_done;
	far_res_t  div_quot;
	far_res_t  div_rem;
	logic      out_load;

	always_comb begin
		case (req.opcode)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: op_in = far_op_t'(req.opcode);
			default: op_in = OP_RED;
		endcase
	end

	always_comb begin
		case (cnt_q)
			2'd0: begin
				mul_a = an_q;
				mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
			end
			2'd1: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = (op_q == OP_DIV) ? bn_q : bd_q;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	far_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		div_start = 1'b0;
		div_dvd = p_q;
		div_dsr = q_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = (op_in == OP_RED) ? ST_EUC : ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_q == 2'd3) begin
					state_d = ST_EUC;
				end
			end
			ST_EUC: begin
				if (q_q != '0) begin
					div_start = 1'b1;
					state_d = ST_GCD_WAIT;
				end else if (p_q == '0) begin
					state_d = ST_OUT;
				end else begin
					div_start = 1'b1;
					div_dvd = n_q;
					div_dsr = p_q;
					state_d = ST_NUM_WAIT;
				end
			end
			ST_GCD_WAIT: begin
				if (div_done) begin
					state_d = ST_EUC;
				end
			end
			ST_NUM_WAIT: begin
				div_dvd = d_q;
				div_dsr = p_q;
				if (div_done) begin
					div_start = 1'b1;
					state_d = ST_DEN_WAIT;
				end
			end
			ST_DEN_WAIT: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					op_q <= op_in;
					an_q <= req.a_num;
					ad_q <= req.a_den;
					bn_q <= req.b_num;
					bd_q <= req.b_den;
					cnt_q <= 2'd0;
					n_q <= far_res_t'(req.a_num);
					d_q <= far_res_t'(req.a_den);
					p_q <= far_res_t'(req.a_num);
					q_q <= far_res_t'(req.a_den);
				end
			end
			ST_MUL: begin
				cnt_q <= cnt_q + 2'd1;
				prod_q <= prod;
				case (cnt_q)
					2'd1: n_q <= far_res_t'(prod_q);
					2'd2: begin
						if (op_q == OP_ADD) begin
							n_q <= n_q + far_res_t'(prod_q);
						end else if (op_q == OP_SUB) begin
							n_q <= n_q - far_res_t'(prod_q);
						end
					end
					2'd3: begin
						d_q <= far_res_t'(prod_q);
						p_q <= n_q;
						q_q <= far_res_t'(prod_q);
					end
					default: ;
				endcase
			end
			ST_EUC: begin
				err_q <= (q_q == '0) && (p_q == '0);
			end
			ST_GCD_WAIT: begin
				if (div_done) begin
					p_q <= q_q;
					q_q <= div_rem;
				end
			end
			ST_NUM_WAIT: begin
				if (div_done) begin
					num_q <= div_quot;
				end
			end
			ST_DEN_WAIT: begin
				if (div_done) begin
					den_q <= div_quot;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_num_q <= err_q ? '0 : num_q;
			res_den_q <= err_q ? '0 : den_q;
			zd_q <= err_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.res_num = res_num_q;
	assign rsp.res_den = res_den_q;
	assign rsp.zero_divisor = zd_q;

`ifndef SYNTHESIS
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("A second item was taken while one was in progress.");

	a_zero_divisor_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.zero_divisor |-> rsp.res_num == '0 && rsp.res_den == '0)
		else $error("A zero divisor result is not 0/0.");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_GCD_WAIT || state_q == ST_NUM_WAIT
			|| state_q == ST_DEN_WAIT)
		else $error("The divider finished while no division was awaited.");

	a_out_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> rsp.valid && req.ready)
		else $error("A finished item did not reach the output register.");
`endif

endmodule

@@ test/tb_fraction_arith_reduce_core.sv @@
module tb_fraction_arith_reduce_core import far_pkg::*;;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;
	localparam int RANDOM_PER_PHASE = 550;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 2000;

	typedef struct {
		logic [2:0] opcode;
		far_opnd_t a_num;
		far_opnd_t a_den;
		far_opnd_t b_num;
		far_opnd_t b_den;
	} frac_req_t;

	typedef struct {
		far_res_t num;
		far_res_t den;
		logic zero_div;
	} frac_rsp_t;

	logic clk;
	logic arst_n;

	far_req_if req_ch();
	far_rsp_if rsp_ch();

	fraction_arith_reduce_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	frac_req_t pending_reqs[$];
	frac_rsp_t reduced_fracs[$];
	int src_idle_pct;
	int snk_idle_pct;
	int error_cnt;
	int idle_cycles;
	int items_in;
	int results_out;
	int zero_div_seen;
	int inf_seen;
	int op_seen[8];
	bit req_taken;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic frac_rsp_t reduce_fraction(frac_req_t it);
		longint an, ad, bn, bd, n, d, p, q, r;
		frac_rsp_t o;
		an = it.a_num;
		ad = it.a_den;
		bn = it.b_num;
		bd = it.b_den;
		case (it.opcode)
			OP_ADD: begin
				n = an * bd + bn * ad;
				d = ad * bd;
			end
			OP_SUB: begin
				n = an * bd - bn * ad;
				d = ad * bd;
			end
			OP_MUL: begin
				n = an * bn;
				d = ad * bd;
			end
			OP_DIV: begin
				n = an * bd;
				d = ad * bn;
			end
			default: begin
				n = an;
				d = ad;
			end
		endcase
		// The remainder truncates toward zero, so the divisor may come out negative.
		p = n;
		q = d;
		while (q != 0) begin
			r = p % q;
			p = q;
			q = r;
		end
		if (p == 0) begin
			o.num = '0;
			o.den = '0;
			o.zero_div = 1'b1;
		end else begin
			o.num = far_res_t'(n / p);
			o.den = far_res_t'(d / p);
			o.zero_div = 1'b0;
		end
		return o;
	endfunction

	function automatic far_opnd_t rand_operand();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			return far_opnd_t'($urandom);
		end else if (pick < 35) begin
			case ($urandom_range(4))
				0: return far_opnd_t'(-32768);
				1: return far_opnd_t'(32767);
				2: return far_opnd_t'(1);
				3: return far_opnd_t'(-1);
				default: return far_opnd_t'(0);
			endcase
		end
		return far_opnd_t'(int'($urandom_range(80)) - 40);
	endfunction

	task automatic push_req(logic [2:0] op, int an, int ad, int bn, int bd);
		frac_req_t it;
		it.opcode = op;
		it.a_num = far_opnd_t'(an);
		it.a_den = far_opnd_t'(ad);
		it.b_num = far_opnd_t'(bn);
		it.b_den = far_opnd_t'(bd);
		pending_reqs.push_back(it);
	endtask

	task automatic push_random(int cnt);
		frac_req_t it;
		for (int i = 0; i < cnt; i++) begin
			if ($urandom_range(99) < 90) begin
				it.opcode = 3'($urandom_range(OP_RED, OP_ADD));
			end else begin
				it.opcode = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
			end
			it.a_num = rand_operand();
			it.a_den = rand_operand();
			it.b_num = rand_operand();
			it.b_den = rand_operand();
			pending_reqs.push_back(it);
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || reduced_fracs.size() != 0) begin
			@(negedge clk);
		end
		#1;
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (!req_ch.valid || req_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.opcode <= pending_reqs[0].opcode;
					req_ch.a_num <= pending_reqs[0].a_num;
					req_ch.a_den <= pending_reqs[0].a_den;
					req_ch.b_num <= pending_reqs[0].b_num;
					req_ch.b_den <= pending_reqs[0].b_den;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		frac_req_t it;
		frac_rsp_t exp_rsp;
		bit rsp_taken;
		req_taken = arst_n && req_ch.valid && req_ch.ready;
		rsp_taken = arst_n && rsp_ch.valid && rsp_ch.ready;
		if (req_taken) begin
			it = pending_reqs.pop_front();
			reduced_fracs.push_back(reduce_fraction(it));
			op_seen[it.opcode]++;
			items_in++;
		end
		if (rsp_taken) begin
			results_out++;
			if (rsp_ch.zero_divisor) begin
				zero_div_seen++;
			end
			if (!rsp_ch.zero_divisor && rsp_ch.res_den == 0) begin
				inf_seen++;
			end
			if (reduced_fracs.size() == 0) begin
				$error("result with nothing expected: %0d/%0d", rsp_ch.res_num, rsp_ch.res_den);
				error_cnt++;
			end else begin
				exp_rsp = reduced_fracs.pop_front();
				if (rsp_ch.res_num !== exp_rsp.num) begin
					$error("res_num: expected %0d, got %0d", exp_rsp.num, rsp_ch.res_num);
					error_cnt++;
				end
				if (rsp_ch.res_den !== exp_rsp.den) begin
					$error("res_den: expected %0d, got %0d", exp_rsp.den, rsp_ch.res_den);
					error_cnt++;
				end
				if (rsp_ch.zero_divisor !== exp_rsp.zero_div) begin
					$error("zero_divisor: expected %0b, got %0b", exp_rsp.zero_div,
						rsp_ch.zero_divisor);
					error_cnt++;
				end
			end
		end
		if (req_taken || rsp_taken || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d items pending", reduced_fracs.size());
			$display("tb_fraction_arith_reduce_core failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_ADD;
		req_ch.a_num = '0;
		req_ch.a_den = '0;
		req_ch.b_num = '0;
		req_ch.b_den = '0;
		rsp_ch.ready = 1'b0;
		src_idle_pct = 16;
		snk_idle_pct = 86;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		#1;

		push_req(OP_ADD, -32768, -32768, -32768, -32768);
		push_req(OP_ADD, 32767, 32767, 32767, 32767);
		push_req(OP_SUB, 32767, -32768, -32768, 32767);
		push_req(OP_SUB, 3, 4, 3, 4);
		push_req(OP_MUL, -32768, 1, -32768, 1);
		push_req(OP_MUL, 0, 0, 123, -45);
		push_req(OP_DIV, 1, -32768, 0, 5);
		push_req(OP_DIV, -32768, 32767, -32768, 32767);
		push_req(OP_DIV, 7, 9, 0, 0);
		push_req(OP_ADD, 0, 0, 0, 0);
		push_req(OP_RED, 0, 0, 1234, -4321);
		push_req(OP_RED, 0, -7, 0, 0);
		push_req(OP_RED, 5, 0, -1, -1);
		push_req(OP_RED, -5, 0, 0, 0);
		push_req(OP_RED, 6, -4, 0, 0);
		push_req(OP_RED, -32768, -32768, 0, 0);
		push_req(OP_RED, 28657, 17711, 0, 0);
		push_req(OP_ADD, 28657, 17711, -17711, 10946);
		push_req(OP_SPARE_FIRST, -12, 18, 32767, -32768);
		push_req(OP_SPARE_MID, 32767, -1, 0, 0);
		push_req(OP_SPARE_LAST, 0, 0, -32768, 32767);
		push_random(RANDOM_PER_PHASE);
		drain();

		src_idle_pct = 86;
		snk_idle_pct = 16;
		push_random(RANDOM_PER_PHASE);
		drain();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		push_random(RANDOM_PER_PHASE);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d items in, %0d results out; per opcode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
			items_in, results_out, op_seen[0], op_seen[1], op_seen[2], op_seen[3],
			op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
		$display("%0d results were 0/0 with zero divisor, %0d had a zero denominator only",
			zero_div_seen, inf_seen);
		if (error_cnt == 0 && reduced_fracs.size() == 0) begin
			$display("tb_fraction_arith_reduce_core passed");
		end else begin
			$display("tb_fraction_arith_reduce_core failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/far_pkg.sv
hw/rtl/far_if.sv
hw/rtl/far_div.sv
hw/rtl/fraction_arith_reduce_core.sv
test/tb_fraction_arith_reduce_core.sv
